// ===== sv/urlm_pkg.sv =====
// urlm_pkg: constants, codes and link types shared by the url rule matcher
// no dependencies; imported by urlm_cell, urlm_rule and url_wildcard_rule_matcher_core
package urlm_pkg;

	localparam int MAX_RULES       = 8;
	localparam int MAX_PATTERN_LEN = 32;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int RULE_W = $clog2(MAX_RULES);
	localparam int CNT_W  = $clog2(MAX_RULES + 1);
	localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
	localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);

	localparam logic [CHAR_W-1:0] WILDCARD_CHAR = 8'h2A;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WR_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET_LEN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_URL     = 2'd2;

	// per-byte control broadcast to every cell of a rule
	typedef struct packed {
		logic              advance;
		logic              start;
		logic [CHAR_W-1:0] url_char;
		logic [CHAR_W-1:0] wdata;
	} cell_ctrl_t;

	// signals handed from one position cell to the next
	typedef struct packed {
		logic ac;   // wildcard closure of the current activity
		logic fwd;  // literal match moving one position on
		logic nc;   // wildcard closure of the next activity
	} cell_link_t;

endpackage

// ===== sv/urlm_cell.sv =====
// urlm_cell: one pattern position, holds the pattern byte and its activity bit
// depends on urlm_pkg
module urlm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  urlm_pkg::cell_ctrl_t ctrl,
	input  logic               we,
	input  logic               inl,
	input  logic               seed,
	input  urlm_pkg::cell_link_t link_in,
	output urlm_pkg::cell_link_t link_out,
	output logic               nc,
	output logic               star_in_len
);
	import urlm_pkg::*;

	logic [CHAR_W-1:0] char_q;
	logic              act_q;
	logic              is_star;
	logic              star_en;
	logic              act_cur;
	logic              ac;
	logic              n_cur;

	// pattern byte, undefined until written
	always_ff @(posedge clk) begin
		if (we) begin
			char_q <= ctrl.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctrl.advance) begin
			act_q <= nc;
		end
	end

	always_comb begin
		is_star     = (char_q == WILDCARD_CHAR);
		star_en     = is_star & inl;
		act_cur     = (act_q & ~ctrl.start) | seed;
		ac          = act_cur | link_in.ac;
		n_cur       = (ac & star_en) | link_in.fwd;
		nc          = n_cur | link_in.nc;
		star_in_len = star_en;
		link_out.ac  = ac & star_en;
		link_out.fwd = ac & inl & ~is_star & (char_q == ctrl.url_char);
		link_out.nc  = nc & star_en;
	end

endmodule

// ===== sv/urlm_rule.sv =====
// urlm_rule: one rule as a chain of position cells plus its length and found flag
// depends on urlm_pkg and urlm_cell
module urlm_rule (
	input  logic                       clk,
	input  logic                       arst_n,
	input  urlm_pkg::cell_ctrl_t       ctrl,
	input  logic                       char_we,
	input  logic [urlm_pkg::POS_W-1:0] wr_pos,
	input  logic                       len_we,
	input  logic [urlm_pkg::LEN_W-1:0] len_value,
	output logic                       match
);
	import urlm_pkg::*;

	logic [LEN_W-1:0]         len_q;
	logic                     found_q;
	cell_link_t               link [MAX_PATTERN_LEN+1];
	logic [MAX_PATTERN_LEN:0] nc_vec;
	logic [MAX_PATTERN_LEN-1:0] star_vec;
	logic                     has_star;
	logic                     subst;
	logic                     end_hit;
	logic                     found_next;

	assign has_star = |star_vec;
	assign subst    = ~has_star;
	// plain rules restart a match at position zero on every byte
	assign link[0]  = '{ac: 1'b0, fwd: subst, nc: 1'b0};

	for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_cell
		logic seed;
		if (i == 0) begin : g_head
			assign seed = ctrl.start | subst;
		end else begin : g_body
			assign seed = 1'b0;
		end
		urlm_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.we          (char_we && (wr_pos == POS_W'(i))),
			.inl         (len_q > LEN_W'(i)),
			.seed        (seed),
			.link_in     (link[i]),
			.link_out    (link[i+1]),
			.nc          (nc_vec[i]),
			.star_in_len (star_vec[i])
		);
	end

	assign nc_vec[MAX_PATTERN_LEN] = link[MAX_PATTERN_LEN].fwd | link[MAX_PATTERN_LEN].nc;

	always_comb begin
		end_hit    = nc_vec[len_q];
		found_next = (found_q & ~ctrl.start) | (subst & end_hit);
		match      = has_star ? end_hit : found_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (len_we) begin
				len_q <= len_value;
			end
			if (ctrl.advance) begin
				found_q <= found_next;
			end
		end
	end

endmodule

// ===== sv/url_wildcard_rule_matcher_core.sv =====
// url_wildcard_rule_matcher_core: top level, rule table of cell chains and result buffer
// depends on urlm_pkg and urlm_rule (which uses urlm_cell)
//
// channel   signals                        direction  transaction
// item      item_valid / item_stall        in         one load command or url byte
// result    result_valid / result_stall    out        block flag after a last url byte
// cfg       cfg_valid / cfg_ready          in         active rule count write
//
// cycles: one item per cycle while item_stall is low; every pattern position of every
//   rule updates in the same cycle; the longest path is a rule's 32-cell wildcard ripple
// a result is registered in the output register, or in the skid entry while that is occupied
// reset clears lengths, activity, found flags and the count; pattern bytes are not reset
// stalls: a two-entry result buffer lets items flow while a result waits; item_stall
//   rises only once both entries hold results
module url_wildcard_rule_matcher_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [urlm_pkg::KIND_W-1:0] kind,
	input  logic [urlm_pkg::RULE_W-1:0] rule_index,
	input  logic [urlm_pkg::POS_W-1:0]  position,
	input  logic [urlm_pkg::CHAR_W-1:0] pattern_char,
	input  logic [urlm_pkg::LEN_W-1:0]  rule_length,
	input  logic [urlm_pkg::CHAR_W-1:0] url_byte,
	input  logic                        last,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        block,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [urlm_pkg::CNT_W-1:0]  cfg_data
);
	import urlm_pkg::*;

	logic                 accept;
	logic                 advance;
	logic                 new_result;
	logic                 hit;
	logic [LEN_W-1:0]     len_sat;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_eff;
	logic                 at_url_start_q;
	cell_ctrl_t           ctrl;
	logic [MAX_RULES-1:0] match_vec;
	logic [MAX_RULES-1:0] enable_vec;

	// result buffer: main output register plus one skid entry
	logic result_valid_q;
	logic block_q;
	logic skid_valid_q;
	logic skid_block_q;
	logic out_take;

	assign cfg_ready    = 1'b1;
	assign item_stall   = skid_valid_q;
	assign result_valid = result_valid_q;
	assign block        = block_q;

	assign accept     = item_valid & ~item_stall;
	assign advance    = accept & (kind == KIND_URL);
	assign new_result = advance & last;
	assign out_take   = result_valid_q & ~result_stall;

	// lengths above the cell count saturate
	assign len_sat = (rule_length > LEN_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN)
	                                                        : rule_length;
	assign count_eff = (count_q > CNT_W'(MAX_RULES)) ? CNT_W'(MAX_RULES) : count_q;

	// broadcast to every cell of every rule
	always_comb begin
		ctrl.advance  = advance;
		ctrl.start    = at_url_start_q;
		ctrl.url_char = url_byte;
		ctrl.wdata    = pattern_char;
	end

	for (genvar r = 0; r < MAX_RULES; r++) begin : g_rule
		urlm_rule u_rule (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.char_we   (accept && (kind == KIND_WR_CHAR) && (rule_index == RULE_W'(r))),
			.wr_pos    (position),
			.len_we    (accept && (kind == KIND_SET_LEN) && (rule_index == RULE_W'(r))),
			.len_value (len_sat),
			.match     (match_vec[r])
		);
		// every rule advances, only those below the count vote
		assign enable_vec[r] = (count_eff > CNT_W'(r));
	end

	assign hit = |(match_vec & enable_vec);

	// active rule count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// start-of-url flag, set again after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_url_start_q <= 1'b1;
		end else if (advance) begin
			at_url_start_q <= last;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (skid_valid_q) begin
			// input is stalled here, so only drain
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (new_result) begin
			if (result_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				result_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			result_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				block_q <= skid_block_q;
			end
		end else if (new_result) begin
			if (result_valid_q && !out_take) begin
				skid_block_q <= hit;
			end else begin
				block_q <= hit;
			end
		end
	end

	// a waiting skid entry always has a result in front of it
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> result_valid_q)
		else $error("skid entry held without a main result");

	// after a taken last url byte the output register always holds a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (kind == KIND_URL) && last) |=> result_valid_q)
		else $error("last url byte produced no result");

	// the next url starts fresh after a last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (kind == KIND_URL) && last) |=> at_url_start_q)
		else $error("start flag not set after last byte");

	// the skid fills only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(result_valid_q && result_stall))
		else $error("skid filled while output was free");

endmodule
